// ===== src/lfid_pkg.sv =====
// Shared types, constants and helpers for the lowest free id allocator.
// Used by every module under src; depends on nothing.
`timescale 1ns / 1ps

package lfid_pkg;

	localparam int MaxIds = 256;
	localparam int IdW = 9;
	localparam int WordW = 8;
	localparam int NumWords = MaxIds / WordW;
	localparam int WordIdxW = $clog2(NumWords);
	localparam int BitIdxW = $clog2(WordW);
	localparam int StatusW = 2;

	localparam logic [StatusW-1:0] StOk = 2'd0;
	localparam logic [StatusW-1:0] StFull = 2'd1;
	localparam logic [StatusW-1:0] StNoId = 2'd2;

	localparam logic FuncAssign = 1'b0;
	localparam logic FuncRelease = 1'b1;

	typedef logic [WordW-1:0] word_t;
	typedef logic [WordIdxW-1:0] widx_t;
	typedef logic [BitIdxW-1:0] bidx_t;
	typedef logic [IdW-1:0] id_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_MOD_RD,
		ST_MOD_WR,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		widx_t addr;
		word_t wdata;
	} mem_req_t;

	// Word 0 holds id 1, which is used after reset.
	function automatic word_t reset_word(input widx_t idx);
		word_t w;
		w = '0;
		if (idx == '0) begin
			w[0] = 1'b1;
		end
		return w;
	endfunction

	function automatic word_t onehot_bit(input bidx_t b);
		return word_t'(1) << b;
	endfunction

endpackage

// ===== src/lfid_bitmap.sv =====
// Used-bit bitmap: word memory with registered read and per-word valid flags.
// Unwritten words read as their reset value. Depends on lfid_pkg.
`timescale 1ns / 1ps

module lfid_bitmap (
	input  logic              clk,
	input  logic              arst_n,
	input  lfid_pkg::mem_req_t req,
	output lfid_pkg::word_t   rword
);

	lfid_pkg::word_t mem [lfid_pkg::NumWords];
	lfid_pkg::word_t rdata_q;
	lfid_pkg::widx_t raddr_q;
	logic [lfid_pkg::NumWords-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.addr];
			raddr_q <= req.addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.addr] <= 1'b1;
		end
	end

	assign rword = valid_q[raddr_q] ? rdata_q : lfid_pkg::reset_word(raddr_q);

endmodule

// ===== src/lfid_scan.sv =====
// Shared search unit: lowest clear bit of one bitmap word whose id lies in
// 2..high-water mark. Depends on lfid_pkg.
`timescale 1ns / 1ps

module lfid_scan (
	input  lfid_pkg::word_t word,
	input  lfid_pkg::widx_t widx,
	input  lfid_pkg::id_t   hw,
	output logic            found,
	output lfid_pkg::bidx_t fbit
);

	lfid_pkg::word_t cand;

	always_comb begin
		lfid_pkg::id_t id;
		for (int b = 0; b < lfid_pkg::WordW; b++) begin
			id = lfid_pkg::id_t'({widx, lfid_pkg::bidx_t'(b)}) + lfid_pkg::id_t'(1);
			cand[b] = !word[b] && (id >= lfid_pkg::id_t'(2)) && (id <= hw);
		end
	end

	always_comb begin
		found = 1'b0;
		fbit = '0;
		for (int b = lfid_pkg::WordW - 1; b >= 0; b--) begin
			if (cand[b]) begin
				found = 1'b1;
				fbit = lfid_pkg::bidx_t'(b);
			end
		end
	end

endmodule

// ===== src/lfid_ctrl.sv =====
// Sequencer: walks bitmap words through the search unit, does read-modify-write
// updates, tracks the high-water mark and holds the result beat. Depends on
// lfid_pkg and lfid_scan.
`timescale 1ns / 1ps

module lfid_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      func,
	input  lfid_pkg::id_t             pid_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output lfid_pkg::id_t             pid_out,
	output logic [lfid_pkg::StatusW-1:0] status,
	output lfid_pkg::mem_req_t        mem_req,
	input  lfid_pkg::word_t           rword
);

	lfid_pkg::state_t state_q, state_d;
	lfid_pkg::widx_t w_q;
	lfid_pkg::bidx_t bit_q;
	logic set_q;
	lfid_pkg::id_t hw_q;
	lfid_pkg::id_t res_pid_q;
	logic [lfid_pkg::StatusW-1:0] res_status_q;
	logic out_valid_q;
	lfid_pkg::id_t pid_out_q;
	logic [lfid_pkg::StatusW-1:0] status_q;

	logic found;
	lfid_pkg::bidx_t fbit;
	lfid_pkg::id_t hw_m1;
	lfid_pkg::id_t pid_m1;
	lfid_pkg::widx_t last_w;
	logic pid_ok;
	logic last_word;
	logic at_max;
	logic slot_free;

	lfid_scan u_scan (
		.word (rword),
		.widx (w_q),
		.hw   (hw_q),
		.found(found),
		.fbit (fbit)
	);

	assign hw_m1 = hw_q - lfid_pkg::id_t'(1);
	assign pid_m1 = pid_in - lfid_pkg::id_t'(1);
	assign last_w = hw_m1[lfid_pkg::BitIdxW +: lfid_pkg::WordIdxW];
	assign pid_ok = (pid_in != '0) && (pid_in <= hw_q);
	assign last_word = (w_q == last_w);
	assign at_max = (hw_q == lfid_pkg::id_t'(lfid_pkg::MaxIds));
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			lfid_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (func == lfid_pkg::FuncRelease) begin
						state_d = pid_ok ? lfid_pkg::ST_MOD_RD : lfid_pkg::ST_FINISH;
					end else begin
						state_d = lfid_pkg::ST_SCAN_RD;
					end
				end
			end
			lfid_pkg::ST_SCAN_RD: state_d = lfid_pkg::ST_SCAN_CHK;
			lfid_pkg::ST_SCAN_CHK: begin
				if (found) begin
					state_d = lfid_pkg::ST_FINISH;
				end else if (!last_word) begin
					state_d = lfid_pkg::ST_SCAN_RD;
				end else if (at_max) begin
					state_d = lfid_pkg::ST_FINISH;
				end else begin
					state_d = lfid_pkg::ST_MOD_RD;
				end
			end
			lfid_pkg::ST_MOD_RD: state_d = lfid_pkg::ST_MOD_WR;
			lfid_pkg::ST_MOD_WR: state_d = lfid_pkg::ST_FINISH;
			lfid_pkg::ST_FINISH: begin
				if (slot_free) begin
					state_d = lfid_pkg::ST_IDLE;
				end
			end
			default: state_d = lfid_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		mem_req = '0;
		case (state_q)
			lfid_pkg::ST_IDLE: in_ready = 1'b1;
			lfid_pkg::ST_SCAN_RD, lfid_pkg::ST_MOD_RD: begin
				mem_req.rd_en = 1'b1;
				mem_req.addr = w_q;
			end
			lfid_pkg::ST_SCAN_CHK: begin
				mem_req.wr_en = found;
				mem_req.addr = w_q;
				mem_req.wdata = rword | lfid_pkg::onehot_bit(fbit);
			end
			lfid_pkg::ST_MOD_WR: begin
				mem_req.wr_en = 1'b1;
				mem_req.addr = w_q;
				mem_req.wdata = set_q ? (rword | lfid_pkg::onehot_bit(bit_q))
				                      : (rword & ~lfid_pkg::onehot_bit(bit_q));
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfid_pkg::ST_IDLE;
			hw_q <= lfid_pkg::id_t'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lfid_pkg::ST_SCAN_CHK && !found && last_word && !at_max) begin
				hw_q <= hw_q + lfid_pkg::id_t'(1);
			end
			if (state_q == lfid_pkg::ST_FINISH && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			lfid_pkg::ST_IDLE: begin
				w_q <= '0;
				bit_q <= pid_m1[lfid_pkg::BitIdxW-1:0];
				set_q <= 1'b0;
				res_pid_q <= '0;
				res_status_q <= lfid_pkg::StOk;
				if (func == lfid_pkg::FuncRelease) begin
					w_q <= pid_m1[lfid_pkg::BitIdxW +: lfid_pkg::WordIdxW];
					if (!pid_ok) begin
						res_status_q <= lfid_pkg::StNoId;
					end
				end
			end
			lfid_pkg::ST_SCAN_CHK: begin
				if (found) begin
					res_pid_q <= lfid_pkg::id_t'({w_q, fbit}) + lfid_pkg::id_t'(1);
				end else if (!last_word) begin
					w_q <= w_q + lfid_pkg::widx_t'(1);
				end else if (at_max) begin
					res_status_q <= lfid_pkg::StFull;
				end else begin
					w_q <= hw_q[lfid_pkg::BitIdxW +: lfid_pkg::WordIdxW];
					bit_q <= hw_q[lfid_pkg::BitIdxW-1:0];
					set_q <= 1'b1;
					res_pid_q <= hw_q + lfid_pkg::id_t'(1);
				end
			end
			lfid_pkg::ST_FINISH: begin
				if (slot_free) begin
					pid_out_q <= res_pid_q;
					status_q <= res_status_q;
				end
			end
			default: begin
				res_status_q <= res_status_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign pid_out = pid_out_q;
	assign status = status_q;

endmodule

// ===== src/lowest_free_id_allocator_top.sv =====
// Lowest free id allocator: ids 1..high-water mark with a used bit each, kept
// as 32 words of 8 bits in a single-port bitmap memory. An assign beat scans
// the words from the lowest one through a shared 8-bit search unit, each word
// read from memory and then checked, and stops at the first word with a free
// id. When no word up to the mark has a free id, a new id past the mark is
// created with a read-modify-write, unless the table is full; at most 32 words
// are read. A release does a read-modify-write; an invalid release skips it.
// One beat is in flight at a time; the result sits in an output register, so
// the next beat is taken while it waits. Status: 0 ok, 1 table full, 2 release
// of an id that does not exist. Depends on lfid_pkg, lfid_ctrl, lfid_bitmap.
`timescale 1ns / 1ps

module lowest_free_id_allocator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [lfid_pkg::IdW-1:0]      pid_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lfid_pkg::IdW-1:0]      pid_out,
	output logic [lfid_pkg::StatusW-1:0]  status
);

	lfid_pkg::mem_req_t mem_req;
	lfid_pkg::word_t rword;

	lfid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.pid_in   (pid_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pid_out  (pid_out),
		.status   (status),
		.mem_req  (mem_req),
		.rword    (rword)
	);

	lfid_bitmap u_bitmap (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mem_req),
		.rword (rword)
	);

endmodule
